// ----- rtl/core/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants and types of the ARP cache and responder core.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES);

  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 4;

  // input opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_RECV   = 2'd2;

  // result actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_HIT   = 2'd1;
  localparam logic [1:0] ACT_REQ   = 2'd2;
  localparam logic [1:0] ACT_REPLY = 2'd3;

  // operation field of a packet to send
  localparam logic [1:0] SEND_NONE  = 2'd0;
  localparam logic [1:0] SEND_REQ   = 2'd1;
  localparam logic [1:0] SEND_REPLY = 2'd2;

  // received ARP header checks
  localparam logic [HALF_W-1:0] HTYPE_ETH   = 16'h0001;
  localparam logic [HALF_W-1:0] PTYPE_IPV4  = 16'h0800;
  localparam logic [HALF_W-1:0] OPER_REQ    = 16'h0001;
  localparam logic [HALF_W-1:0] MIN_ARP_LEN = 16'd28;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // register indexes (paddr[3])
  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [MAC_W-1:0]  mac;
  } arpc_tok_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
  } arpc_wr_t;

endpackage

// ----- rtl/core/arpc_if.sv -----
// ----------------------------------------------------------------------------
// arpc_if
// Valid/ready channels of the ARP core: request items and result items.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  import arpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [IP_W-1:0]   ip_addr;
  logic [MAC_W-1:0]  mac_addr;
  logic [HALF_W-1:0] hw_type;
  logic [HALF_W-1:0] proto_type;
  logic [HALF_W-1:0] arp_oper;
  logic [IP_W-1:0]   tgt_ip;
  logic [HALF_W-1:0] frame_len;

  modport source (
    output valid, opcode, ip_addr, mac_addr, hw_type, proto_type, arp_oper,
           tgt_ip, frame_len,
    input  ready
  );
  modport sink (
    input  valid, opcode, ip_addr, mac_addr, hw_type, proto_type, arp_oper,
           tgt_ip, frame_len,
    output ready
  );
endinterface

interface arpc_rsp_if;
  import arpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [MAC_W-1:0] mac_out;
  logic [1:0]       send_oper;
  logic [MAC_W-1:0] send_target_mac;
  logic [IP_W-1:0]  send_target_ip;

  modport source (
    output valid, action, mac_out, send_oper, send_target_mac, send_target_ip,
    input  ready
  );
  modport sink (
    input  valid, action, mac_out, send_oper, send_target_mac, send_target_ip,
    output ready
  );
endinterface

// ----- rtl/core/arp_cache_and_responder_core.sv -----
// ----------------------------------------------------------------------------
// arp_cache_and_responder_core
// ARP cache for IPv4 over Ethernet with a responder for requests to own IP.
//
// Channels: req_i takes one item per event (lookup, static set, received ARP
// packet); rsp_o gives exactly one result item per request item. Both use
// valid/ready; an item moves when both are high at a rising edge. The APB
// port writes own_mac (byte address 0) and own_ip (byte address 8).
// Table: TABLE_ENTRIES cells in a row, each holding one entry. A lookup or an
// accepted packet sends a search token down the row, one cell per cycle;
// the lowest valid matching entry claims it. The entry update is broadcast
// to the cells when the token leaves the last cell.
// Flow: lookups and accepted packets give their result once the token has
// left the last cell; static sets, dropped packets and the unused opcode
// skip the walk. The next item can be taken once the result has loaded
// into the output register.
// One item is in work at a time; a new item may be accepted while the
// previous result still waits.
// Reset: all entries invalid, replacement slot zero, both registers zero.
// Stall: a result waits in the output register until taken; the core holds
// the next finished result and takes no further item meanwhile.
// ----------------------------------------------------------------------------
module arp_cache_and_responder_core
  import arpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  arpc_req_if.sink          req_i,
  arpc_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;

  logic [IP_W-1:0]  own_ip;

  // latched item
  logic [1:0]       op_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic             pkt_ok_q;
  logic             reply_q;

  logic [SLOT_W-1:0] slot_q, slot_d;

  // pending result
  logic [1:0]       act_q, act_d;
  logic [MAC_W-1:0] rmac_q, rmac_d;
  logic [1:0]       roper_q, roper_d;
  logic [MAC_W-1:0] rtmac_q, rtmac_d;
  logic [IP_W-1:0]  rtip_q, rtip_d;

  // output register
  logic             out_valid_q;
  logic [1:0]       out_act_q;
  logic [MAC_W-1:0] out_mac_q;
  logic [1:0]       out_oper_q;
  logic [MAC_W-1:0] out_tmac_q;
  logic [IP_W-1:0]  out_tip_q;

  arpc_tok_t tok [TABLE_ENTRIES+1];
  arpc_wr_t  wr;
  logic      accept;
  logic      need_search;
  logic      out_free;
  logic      pkt_ok;
  logic [SLOT_W-1:0] slot_inc;

  arpc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .own_ip_o  (own_ip)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign pkt_ok = (req_i.frame_len >= MIN_ARP_LEN) && (req_i.hw_type == HTYPE_ETH) &&
                  (req_i.proto_type == PTYPE_IPV4);

  // latch the item; the reply check is taken from own_ip at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.opcode;
      ip_q     <= req_i.ip_addr;
      mac_q    <= req_i.mac_addr;
      pkt_ok_q <= pkt_ok;
      reply_q  <= (req_i.arp_oper == OPER_REQ) && (req_i.tgt_ip == own_ip);
    end
  end

  assign need_search = (op_q == OP_LOOKUP) || ((op_q == OP_RECV) && pkt_ok_q);

  // launch the token from the head of the row
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = (state_q == ST_DECIDE) && need_search;
  end

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
    arpc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (SLOT_W'(gi)),
      .key_ip_i   (ip_q),
      .wr_i       (wr),
      .tok_i      (tok[gi]),
      .tok_o      (tok[gi+1])
    );
  end

  assign slot_inc = (slot_q == SLOT_W'(TABLE_ENTRIES - 1)) ? '0 : slot_q + 1'b1;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    wr      = '0;
    wr.ip   = ip_q;
    wr.mac  = mac_q;
    act_d   = act_q;
    rmac_d  = rmac_q;
    roper_d = roper_q;
    rtmac_d = rtmac_q;
    rtip_d  = rtip_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // default result: nothing
        act_d   = ACT_NONE;
        rmac_d  = '0;
        roper_d = SEND_NONE;
        rtmac_d = '0;
        rtip_d  = '0;
        if (need_search) begin
          state_d = ST_SEARCH;
        end else begin
          state_d = ST_EMIT;
          if (op_q == OP_SET) begin
            wr.en  = 1'b1;
            wr.idx = slot_q;
            slot_d = slot_inc;
          end
        end
      end
      ST_SEARCH: begin
        if (tok[TABLE_ENTRIES].valid) begin
          state_d = ST_EMIT;
          if (op_q == OP_LOOKUP) begin
            if (tok[TABLE_ENTRIES].found) begin
              act_d  = ACT_HIT;
              rmac_d = tok[TABLE_ENTRIES].mac;
            end else begin
              act_d   = ACT_REQ;
              rmac_d  = MAC_BCAST;
              roper_d = SEND_REQ;
              rtip_d  = ip_q;
            end
          end else begin
            // refresh the matching entry, else take the replacement slot
            wr.en = 1'b1;
            if (tok[TABLE_ENTRIES].found) begin
              wr.idx = tok[TABLE_ENTRIES].idx;
              wr.ip  = ip_q;
            end else begin
              wr.idx = slot_q;
              slot_d = slot_inc;
            end
            if (reply_q) begin
              act_d   = ACT_REPLY;
              rmac_d  = mac_q;
              roper_d = SEND_REPLY;
              rtmac_d = mac_q;
              rtip_d  = ip_q;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    rmac_q  <= rmac_d;
    roper_q <= roper_d;
    rtmac_q <= rtmac_d;
    rtip_q  <= rtip_d;
    if ((state_q == ST_EMIT) && out_free) begin
      out_act_q  <= act_q;
      out_mac_q  <= rmac_q;
      out_oper_q <= roper_q;
      out_tmac_q <= rtmac_q;
      out_tip_q  <= rtip_q;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.action          = out_act_q;
  assign rsp_o.mac_out         = out_mac_q;
  assign rsp_o.send_oper       = out_oper_q;
  assign rsp_o.send_target_mac = out_tmac_q;
  assign rsp_o.send_target_ip  = out_tip_q;

endmodule

// ----- rtl/core/arpc_regs.sv -----
// ----------------------------------------------------------------------------
// arpc_regs
// APB-style register file holding the own MAC and own IPv4 address.
// ----------------------------------------------------------------------------
module arpc_regs
  import arpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [IP_W-1:0]   own_ip_o
);

  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (wr_en) begin
      if (paddr[3] == REG_OWN_MAC) begin
        own_mac_q <= pwdata[MAC_W-1:0];
      end else begin
        own_ip_q <= pwdata[IP_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == REG_OWN_IP) begin
      prdata = {{(DATA_W-IP_W){1'b0}}, own_ip_q};
    end else begin
      prdata = {{(DATA_W-MAC_W){1'b0}}, own_mac_q};
    end
  end

  assign own_ip_o  = own_ip_q;

endmodule

// ----- rtl/core/arpc_cell.sv -----
// ----------------------------------------------------------------------------
// arpc_cell
// One table entry plus one stage of the search token chain.
// ----------------------------------------------------------------------------
module arpc_cell
  import arpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] cell_idx_i,
  input  logic [IP_W-1:0]   key_ip_i,
  input  arpc_wr_t          wr_i,
  input  arpc_tok_t         tok_i,
  output arpc_tok_t         tok_o
);

  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic             valid_q;
  arpc_tok_t        tok_d, tok_q;
  logic             match;
  logic             wr_here;

  assign wr_here = wr_i.en && (wr_i.idx == cell_idx_i);
  assign match   = valid_q && (ip_q == key_ip_i);

  // first matching cell claims the token
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && match) begin
      tok_d.found = 1'b1;
      tok_d.idx   = cell_idx_i;
      tok_d.mac   = mac_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_here) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      ip_q  <= wr_i.ip;
      mac_q <= wr_i.mac;
    end
  end

  assign tok_o = tok_q;

endmodule
